// ===== src/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int DEF_KEY_BITS = 16;

    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;
    localparam logic [1:0] KIND_REM = 2'd2;
    localparam logic [1:0] KIND_UPD = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_CLOSED = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] entry_key;
        logic [31:0] entry_priority;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_key;
        logic [31:0] out_priority;
        logic [6:0]  occupancy;
    } t_rsp;

endpackage

// ===== src/mhpq_cmp.sv =====
// ----------------------------------------------------------------------------
// mhpq_cmp
// Shared priority comparator used by every sift step.
// ----------------------------------------------------------------------------
module mhpq_cmp (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_lt
);
    assign o_lt = i_a < i_b;
endmodule

// ===== src/min_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of (key, priority) entries with a small sequencer.
// ----------------------------------------------------------------------------
// One command runs at a time. Busy is high from the accepting edge until the
// cycle of the result strobe, and a new item may be taken in that cycle. Each
// step reads heap slots through a registered memory read, and each sift step
// goes through the one shared priority compare. Sifting down steps through
// S_DN, S_DN_A, S_DN_B, S_DN_C and S_DN_X per level, and sifting up through
// S_UP, S_UP_A and S_UP_B. Remove and update first scan the slots at one per
// cycle. Rejected items (closed, full, empty, key not found after the scan)
// finish at once. Results are shown for one cycle on o_rsp with o_rsp_valid
// and cannot be stalled. The heap memory needs no clearing after reset, since
// only slots below the occupancy are ever used.
module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
    parameter int KEY_BITS = mhpq_pkg::DEF_KEY_BITS
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  mhpq_pkg::t_cmd  i_cmd,
    input  logic            i_cfg_we,
    input  logic            i_cfg_closed,
    output logic            o_rsp_valid,
    output mhpq_pkg::t_rsp  o_rsp
);
    import mhpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_W, S_SCAN, S_DQ_W, S_DQ, S_LAST_W, S_LAST,
        S_DN, S_DN_A, S_DN_B, S_DN_C, S_DN_X,
        S_UP, S_UP_A, S_UP_B, S_PLACE, S_DONE
    } t_state;

    logic [KEY_BITS-1:0] mem_k [CAPACITY];
    logic [31:0]         mem_p [CAPACITY];

    t_state              r_state;
    logic                r_closed;
    logic [CW-1:0]       r_count;
    logic [1:0]          r_kind, r_status;
    logic [KEY_BITS-1:0] r_key;
    logic [31:0]         r_prio;
    logic [AW-1:0]       r_pos, r_addr, r_raddr, r_best;
    logic [KEY_BITS-1:0] r_bk, r_ck;
    logic [31:0]         r_bp, r_cp;
    logic [KEY_BITS-1:0] r_ok;
    logic [31:0]         r_op;
    logic                r_up_after;
    logic                r_moved;
    logic                r_rsp_valid;
    logic [KEY_BITS-1:0] r_rk;
    logic [31:0]         r_rp;

    // Registered memory read; r_raddr tells which slot r_rk and r_rp hold.
    always_ff @(posedge i_clk) begin
        r_rk    <= mem_k[r_addr];
        r_rp    <= mem_p[r_addr];
        r_raddr <= r_addr;
    end

    // The moving entry is held in r_bk/r_bp and written only once it settles.
    logic [31:0] cmp_a, cmp_b;
    always_comb begin
        cmp_a = r_cp;
        cmp_b = r_bp;
        case (r_state)
            S_DN_C: begin
                cmp_a = r_rp;
                cmp_b = r_cp;
            end
            S_UP_B: begin
                cmp_a = r_bp;
                cmp_b = r_rp;
            end
            default: ;
        endcase
    end

    logic cmp_lt;
    mhpq_cmp u_cmp (.i_a(cmp_a), .i_b(cmp_b), .o_lt(cmp_lt));

    logic                we;
    logic [AW-1:0]       wa;
    logic [KEY_BITS-1:0] wk;
    logic [31:0]         wp;
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_k[wa] <= wk;
            mem_p[wa] <= wp;
        end
    end

    logic [XW-1:0] lc, rc, cnt_x;
    assign lc    = {1'b0, r_pos, 1'b1};
    assign rc    = {1'b0, r_pos, 1'b0} + XW'(2);
    assign cnt_x = XW'(r_count);
    logic [AW-1:0] par;
    assign par = (r_pos - AW'(1)) >> 1;
    logic [AW:0] next_raddr;
    assign next_raddr = {1'b0, r_raddr} + (AW+1)'(1);

    always_comb begin
        we = 1'b0;
        wa = r_pos;
        wk = r_bk;
        wp = r_bp;
        case (r_state)
            S_DN_X: if (cmp_lt) begin
                we = 1'b1;
                wk = r_ck;
                wp = r_cp;
            end
            S_UP_B: if (cmp_lt) begin
                we = 1'b1;
                wk = r_rk;
                wp = r_rp;
            end
            S_PLACE: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_closed <= 1'b0;
            r_count <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_rsp_valid <= 1'b0;
            if (i_cfg_we) r_closed <= i_cfg_closed;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_kind <= i_cmd.kind;
                    r_key <= KEY_BITS'(i_cmd.entry_key);
                    r_prio <= i_cmd.entry_priority;
                    r_ok <= '0;
                    r_op <= '0;
                    r_addr <= '0;
                    r_moved <= 1'b0;
                    r_up_after <= (i_cmd.kind != KIND_DEQ);
                    unique case (i_cmd.kind)
                        KIND_ENQ: begin
                            if (r_closed) begin
                                r_status <= ST_CLOSED;
                                r_state <= S_DONE;
                            end else if (r_count == CW'(CAPACITY)) begin
                                r_status <= ST_FULL;
                                r_state <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_pos <= AW'(r_count);
                                r_bk <= KEY_BITS'(i_cmd.entry_key);
                                r_bp <= i_cmd.entry_priority;
                                r_count <= r_count + CW'(1);
                                r_state <= S_UP;
                            end
                        end
                        KIND_DEQ: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_state <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_pos <= '0;
                                r_state <= S_DQ_W;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_state <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state <= S_SCAN_W;
                            end
                        end
                    endcase
                end
                S_SCAN_W: begin
                    r_addr <= r_addr + AW'(1);
                    r_state <= S_SCAN;
                end
                // One slot is compared per cycle while the next one is read.
                S_SCAN: begin
                    if (r_rk == r_key) begin
                        r_pos <= r_raddr;
                        if (r_kind == KIND_UPD) begin
                            r_bk <= r_rk;
                            r_bp <= r_prio;
                            r_state <= S_DN;
                        end else begin
                            r_count <= r_count - CW'(1);
                            if (next_raddr == (AW+1)'(r_count)) begin
                                // The last entry itself was removed.
                                r_state <= S_DONE;
                            end else begin
                                r_addr <= AW'(r_count - CW'(1));
                                r_state <= S_LAST_W;
                            end
                        end
                    end else if (next_raddr >= (AW+1)'(r_count)) begin
                        r_status <= ST_EMPTY;
                        r_state <= S_DONE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DQ_W: r_state <= S_DQ;
                S_DQ: begin
                    r_ok <= r_rk;
                    r_op <= r_rp;
                    r_count <= r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_addr <= AW'(r_count - CW'(1));
                        r_state <= S_LAST_W;
                    end
                end
                S_LAST_W: r_state <= S_LAST;
                S_LAST: begin
                    r_bk <= r_rk;
                    r_bp <= r_rp;
                    r_state <= S_DN;
                end
                S_DN: begin
                    if (lc < cnt_x) begin
                        r_addr <= lc[AW-1:0];
                        r_state <= S_DN_A;
                    end else if (r_up_after && !r_moved) begin
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_DN_A: begin
                    r_addr <= rc[AW-1:0];
                    r_state <= S_DN_B;
                end
                S_DN_B: begin
                    r_ck <= r_rk;
                    r_cp <= r_rp;
                    r_best <= lc[AW-1:0];
                    r_state <= S_DN_C;
                end
                // The right child wins only when strictly smaller.
                S_DN_C: begin
                    if (rc < cnt_x && cmp_lt) begin
                        r_ck <= r_rk;
                        r_cp <= r_rp;
                        r_best <= rc[AW-1:0];
                    end
                    r_state <= S_DN_X;
                end
                S_DN_X: begin
                    if (cmp_lt) begin
                        r_pos <= r_best;
                        r_moved <= 1'b1;
                        r_state <= S_DN;
                    end else if (r_up_after && !r_moved) begin
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_UP: begin
                    if (r_pos == '0) begin
                        r_state <= S_PLACE;
                    end else begin
                        r_addr <= par;
                        r_state <= S_UP_A;
                    end
                end
                S_UP_A: r_state <= S_UP_B;
                S_UP_B: begin
                    if (cmp_lt) begin
                        r_pos <= r_raddr;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: r_state <= S_DONE;
                S_DONE: begin
                    r_rsp_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp.status = r_status;
    assign o_rsp.out_key = 16'(r_ok);
    assign o_rsp.out_priority = r_op;
    assign o_rsp.occupancy = 7'(r_count);

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count over capacity");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !busy) else $error("strobe while busy");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid) else $error("double strobe");
`endif
endmodule
